### rtl/dve_pkg.sv
`default_nettype none

package dve_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned DIGIT_W = 7;
    localparam int unsigned BYTE_W  = 8;

    typedef logic [VALUE_W-1:0] value_t;

    // Handoff from the delta stage to the byte serializer
    typedef struct packed {
        logic   valid;
        value_t number;
    } delta_xfer_t;

endpackage

`default_nettype wire

### rtl/dve_delta.sv
`default_nettype none

module dve_delta (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire dve_pkg::value_t       s_value,
    input  wire logic                  s_first,
    output dve_pkg::delta_xfer_t       xfer,
    input  wire logic                  xfer_ready
);

    logic            full_reg;
    logic            full_next;
    dve_pkg::value_t prev_reg;
    dve_pkg::value_t prev_next;
    dve_pkg::value_t number_reg;
    dve_pkg::value_t number_next;
    logic            accept;

    assign s_ready = !full_reg;
    assign accept  = s_valid && s_ready;

    always_comb begin
        full_next   = full_reg;
        prev_next   = prev_reg;
        number_next = number_reg;
        if (full_reg && xfer_ready) begin
            full_next = 1'b0;
        end
        if (accept) begin
            full_next   = 1'b1;
            prev_next   = s_value;
            // First element of a list codes the value itself; wrap otherwise
            number_next = s_first ? s_value : (s_value - prev_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
            prev_reg <= '0;
        end else begin
            full_reg <= full_next;
            prev_reg <= prev_next;
        end
        number_reg <= number_next;
    end

    assign xfer.valid  = full_reg;
    assign xfer.number = number_reg;

endmodule

`default_nettype wire

### rtl/dve_serializer.sv
`default_nettype none

module dve_serializer (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire dve_pkg::delta_xfer_t          xfer,
    output logic                               xfer_ready,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [dve_pkg::BYTE_W-1:0]         m_code_byte,
    output logic                               m_last_byte
);

    logic                          busy_reg;
    logic                          busy_next;
    dve_pkg::value_t               shift_reg;
    dve_pkg::value_t               shift_next;
    logic                          valid_reg;
    logic                          valid_next;
    logic [dve_pkg::BYTE_W-1:0]    byte_reg;
    logic [dve_pkg::BYTE_W-1:0]    byte_next;
    logic                          last_reg;
    logic                          last_next;
    logic                          emit;
    logic                          more;

    assign xfer_ready = !busy_reg;
    assign emit       = busy_reg && (!valid_reg || m_ready);
    assign more       = |shift_reg[dve_pkg::VALUE_W-1:dve_pkg::DIGIT_W];

    always_comb begin
        busy_next  = busy_reg;
        shift_next = shift_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end
        if (emit) begin
            // Send the low group, then advance by one digit
            valid_next = 1'b1;
            byte_next  = {more, shift_reg[dve_pkg::DIGIT_W-1:0]};
            last_next  = !more;
            shift_next = {{dve_pkg::DIGIT_W{1'b0}},
                          shift_reg[dve_pkg::VALUE_W-1:dve_pkg::DIGIT_W]};
            busy_next  = more;
        end else if (!busy_reg && xfer.valid) begin
            busy_next  = 1'b1;
            shift_next = xfer.number;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
        shift_reg <= shift_next;
        byte_reg  <= byte_next;
        last_reg  <= last_next;
    end

    assign m_valid     = valid_reg;
    assign m_code_byte = byte_reg;
    assign m_last_byte = last_reg;

endmodule

`default_nettype wire

### rtl/delta_varint_encoder.sv
`default_nettype none

// Delta + LEB128 varint encoder. Each input transaction carries one 32-bit
// list element; with s_first set the value is coded as is, otherwise its
// difference from the previous element (modulo 2^32). Every coded number
// leaves as 1 to 5 output transactions, one varint byte each, least
// significant 7-bit group first, bit 7 set on all but the final byte, which
// carries m_last_byte. A shift register drops one 7-bit digit per cycle
// into the output register while m_ready does not hold it back. An element
// passes the delta register, is then loaded into the serializer shift
// register, and its bytes then leave through the output register; stalls on
// m_ready hold the output byte. The delta stage takes the next element while
// the serializer is still busy.

module delta_varint_encoder (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [dve_pkg::VALUE_W-1:0]   s_value,
    input  wire logic                          s_first,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [dve_pkg::BYTE_W-1:0]         m_code_byte,
    output logic                               m_last_byte
);

    dve_pkg::delta_xfer_t xfer;
    logic                 xfer_ready;

    dve_delta u_delta (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .s_first    (s_first),
        .xfer       (xfer),
        .xfer_ready (xfer_ready)
    );

    dve_serializer u_serializer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .xfer        (xfer),
        .xfer_ready  (xfer_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_code_byte (m_code_byte),
        .m_last_byte (m_last_byte)
    );

endmodule

`default_nettype wire
